// ===== sv/fccw_pkg.sv =====
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared constants and types for the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fccw_pkg;

	// table geometry
	localparam int TABLE_BYTES = 8192;
	localparam int BYTE_AW     = 13;
	localparam int BANK_DEPTH  = (TABLE_BYTES + 1) / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);

	// chain limits
	localparam int MAX_CHAIN   = 64;
	localparam int CNT_W       = $clog2(MAX_CHAIN + 1);

	localparam int CLUSTER_W   = 12;
	localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF8;

	// item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_WALK = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} fccw_state_t;

endpackage

// ===== sv/fccw_ram.sv =====
// ----------------------------------------------------------------------------
// fccw_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fccw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write on enable, otherwise a registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== sv/fat12_cluster_chain_walker_core.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_core
// Walks a FAT12 allocation table held in on-chip memory.
// ----------------------------------------------------------------------------
// A load item (kind 0) writes one table byte, and busy stays
// low. A walk item (kind 1) emits the chain from head_cluster onward, one
// result per cycle on res_stb, with no way for the receiver to hold them off.
// A walk keeps busy high while it walks, and its first result passes the
// bank read, then the result registers; the table is split into even and odd
// byte banks so both bytes of an entry come from one memory read, and that
// read per link sets the pace. A first cluster at or above 0xFF8 gives its
// single empty result in the cycle after the accept without raising busy.
// Table bytes must be loaded before a walk reads them.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            kind,
	input  logic [fccw_pkg::BYTE_AW-1:0]    byte_addr,
	input  logic [7:0]                      byte_value,
	input  logic [fccw_pkg::CLUSTER_W-1:0]  head_cluster,
	output logic                            res_stb,
	output logic [fccw_pkg::CLUSTER_W-1:0]  cluster,
	output logic                            last,
	output logic                            empty_res,
	output logic                            truncated
);

	import fccw_pkg::*;

	fccw_state_t state_q, state_d;

	logic                 accept;
	logic                 load_acc;
	logic                 walk_acc;
	logic                 load_in_range;

	logic [CLUSTER_W-1:0] cur_q;
	logic [CNT_W-1:0]     n_q;
	logic                 podd_q;
	logic                 oob0_q;
	logic                 oob1_q;

	logic [CLUSTER_W-1:0] rd_cluster;
	logic [BYTE_AW-1:0]   p0;
	logic [BYTE_AW-1:0]   p1;
	logic [BANK_AW-1:0]   even_addr;
	logic [BANK_AW-1:0]   odd_addr;
	logic                 even_we;
	logic                 odd_we;
	logic [7:0]           even_rd;
	logic [7:0]           odd_rd;

	logic [7:0]           b0;
	logic [7:0]           b1;
	logic [CLUSTER_W-1:0] entry;
	logic                 at_end;
	logic                 at_cut;

	logic                 res_stb_q;
	logic [CLUSTER_W-1:0] cluster_q;
	logic                 last_q;
	logic                 empty_q;
	logic                 trunc_q;

	assign busy          = (state_q == ST_WALK);
	assign accept        = start && !busy;
	assign load_acc      = accept && (kind == KIND_LOAD);
	assign walk_acc      = accept && (kind == KIND_WALK);
	assign load_in_range = ({1'b0, byte_addr} < (BYTE_AW+1)'(TABLE_BYTES));

	// extract the entry of the current cluster from the two bank words
	always_comb begin
		b0 = oob0_q ? 8'h00 : (podd_q ? odd_rd : even_rd);
		b1 = oob1_q ? 8'h00 : (podd_q ? even_rd : odd_rd);
		if (cur_q[0]) begin
			entry = {b1, b0[7:4]};
		end else begin
			entry = {b1[3:0], b0};
		end
	end

	assign at_end = (entry >= END_MARK);
	assign at_cut = (n_q == CNT_W'(MAX_CHAIN - 1));

	// address the entry of the cluster to read next: p = c*3/2
	always_comb begin
		rd_cluster = busy ? entry : head_cluster;
		p0         = BYTE_AW'(rd_cluster) + BYTE_AW'(rd_cluster >> 1);
		p1         = p0 + BYTE_AW'(1);
		if (p0[0]) begin
			odd_addr  = p0[BANK_AW:1];
			even_addr = p1[BANK_AW:1];
		end else begin
			even_addr = p0[BANK_AW:1];
			odd_addr  = p0[BANK_AW:1];
		end
		even_we = 1'b0;
		odd_we  = 1'b0;
		// a load takes the port of the bank its byte lives in
		if (load_acc && load_in_range) begin
			if (byte_addr[0]) begin
				odd_we   = 1'b1;
				odd_addr = byte_addr[BANK_AW:1];
			end else begin
				even_we   = 1'b1;
				even_addr = byte_addr[BANK_AW:1];
			end
		end
	end

	fccw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even_bank (
		.clk   (clk),
		.we    (even_we),
		.addr  (even_addr),
		.wdata (byte_value),
		.rdata (even_rd)
	);

	fccw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd_bank (
		.clk   (clk),
		.we    (odd_we),
		.addr  (odd_addr),
		.wdata (byte_value),
		.rdata (odd_rd)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state: walk until an end marker or the cut
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (walk_acc && (head_cluster < END_MARK)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (at_end || at_cut) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// advance the walk position and capture read-side flags
	always_ff @(posedge clk) begin
		if (walk_acc || busy) begin
			cur_q  <= rd_cluster;
			podd_q <= p0[0];
			oob0_q <= ({1'b0, p0} >= (BYTE_AW+1)'(TABLE_BYTES));
			oob1_q <= ({1'b0, p1} >= (BYTE_AW+1)'(TABLE_BYTES));
			n_q    <= busy ? n_q + CNT_W'(1) : '0;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stb_q <= 1'b0;
		end else begin
			res_stb_q <= busy || (walk_acc && (head_cluster >= END_MARK));
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (busy) begin
			cluster_q <= cur_q;
			last_q    <= at_end || at_cut;
			empty_q   <= 1'b0;
			trunc_q   <= !at_end && at_cut;
		end else begin
			cluster_q <= head_cluster;
			last_q    <= 1'b1;
			empty_q   <= 1'b1;
			trunc_q   <= 1'b0;
		end
	end

	assign res_stb   = res_stb_q;
	assign cluster   = cluster_q;
	assign last      = last_q;
	assign empty_res = empty_q;
	assign truncated = trunc_q;

	// a walk that ends leaves its final item on the result port
	a_end_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (res_stb && last))
		else $error("walk ended without a final result");

	// a result that is not the last is followed by another in the next cycle
	a_chain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(res_stb && !last) |-> busy)
		else $error("result gap inside a chain");

	// an end marker as first cluster gives one empty result
	a_empty_start: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_acc && (head_cluster >= END_MARK)) |=>
		(res_stb && empty_res && last && !truncated && !busy))
		else $error("empty walk mishandled");

	// truncation only ever marks the final result of a full-length chain
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_stb && truncated) |-> (last && !empty_res))
		else $error("truncated flag on a non-final result");

	// no load is taken while a walk reads the table
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!even_we && !odd_we))
		else $error("table write during a walk");

endmodule
